// File: design/assert_macros.svh
// Assertion macros shared by the classifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Condition that must hold at every clock edge outside reset.
`define MSC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define MSC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`endif

// File: design/msc_pkg.sv
// Shared types and constants of the masked signature classifier.
package msc_pkg;

    localparam logic [2:0] MODE_BEGIN       = 3'd0;
    localparam logic [2:0] MODE_HEADER      = 3'd1;
    localparam logic [2:0] MODE_NAME        = 3'd2;
    localparam logic [2:0] MODE_RULE_HEADER = 3'd3;
    localparam logic [2:0] MODE_RULE_BYTE   = 3'd4;
    localparam logic [2:0] MODE_RULE_STATUS = 3'd5;
    localparam logic [2:0] MODE_CLASSIFY    = 3'd6;

    localparam logic [1:0] CMD_DISABLE = 2'd0;
    localparam logic [1:0] CMD_ENABLE  = 2'd1;
    localparam logic [1:0] CMD_DELETE  = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_MATCH   = 2'd1;
    localparam logic [1:0] STATUS_PATH_ERROR = 2'd2;
    localparam logic [1:0] STATUS_REJECT     = 2'd3;

    localparam logic [7:0] DOT_CHAR       = 8'h2E;
    localparam int         PATTERN_SLOTS  = 256;
    localparam int         FLAG_OPEN_BIN  = 1;
    localparam int         FLAG_CREDS     = 2;
    localparam int         QUEUE_DEPTH    = 4;
    localparam int         QUEUE_PTR_W    = 2;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] entry;
        logic [7:0] position;
        logic [7:0] byte_value;
        logic [7:0] mask_value;
        logic       is_magic;
        logic       has_mask;
        logic [7:0] start_offset;
        logic [8:0] length;
        logic [3:0] action_flags;
        logic [1:0] command;
        logic       path_inaccessible;
    } item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RULE,
        ST_READ,
        ST_CMP
    } state_t;

endpackage

// File: design/msc_queue.sv
// Short item queue between the accepting front and the executing back end.
module msc_queue
    import msc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head_item
);

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/msc_engine.sv
// Back end: executes queued items, owns the stores and walks the rule table.
module msc_engine
    import msc_pkg::*;
#(
    parameter int RULES        = 16,
    parameter int HEADER_BYTES = 256,
    parameter int EXT_BYTES    = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       global_enable,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_pop,
    output logic       init_done,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_status,
    output logic       out_matched,
    output logic [3:0] out_index,
    output logic [3:0] out_flags
);

`include "assert_macros.svh"

    localparam int RW   = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int HA   = $clog2(HEADER_BYTES);
    localparam int HPW  = (HA > 10) ? HA : 10;
    localparam int EAW  = (EXT_BYTES > 1) ? $clog2(EXT_BYTES) : 1;
    localparam int ELW  = $clog2(EXT_BYTES + 1);
    localparam int PD   = RULES * PATTERN_SLOTS;

    // stores
    logic [7:0] hdr_mem [HEADER_BYTES];
    logic [7:0] ext_mem [EXT_BYTES];
    logic [7:0] pat_mem [PD];
    logic [7:0] msk_mem [PD];
    logic [7:0] hdr_q, ext_q, pat_q, msk_q;

    // rule table
    logic       rule_valid_reg  [RULES];
    logic       rule_enable_reg [RULES];
    logic       rule_magic_reg  [RULES];
    logic       rule_mask_reg   [RULES];
    logic [7:0] rule_offset_reg [RULES];
    logic [8:0] rule_size_reg   [RULES];
    logic [3:0] rule_flags_reg  [RULES];

    state_t          state_reg, state_next;
    logic [HA-1:0]   clr_idx_reg, clr_idx_next;
    logic            init_done_reg, init_done_next;
    logic [ELW-1:0]  ext_len_reg, ext_len_next;
    logic            dot_reg, dot_next;
    logic            ovf_reg, ovf_next;
    logic [RW:0]     r_reg, r_next;
    logic [8:0]      j_reg, j_next;
    logic            path_reg, path_next;
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_status_reg, out_status_next;
    logic            out_matched_reg, out_matched_next;
    logic [3:0]      out_index_reg, out_index_next;
    logic [3:0]      out_flags_reg, out_flags_next;

    logic            hdr_we, ext_we, pat_we, rule_hdr_we, rule_cmd_we;
    logic [HA-1:0]   hdr_wa;
    logic [7:0]      hdr_wd;
    logic            out_free, entry_ok, mismatch;
    logic [RW-1:0]   rsel, esel;
    logic [HPW-1:0]  hp;
    logic [9:0]      magic_end;
    logic [7:0]      cmp_mask;
    logic [3:0]      win_flags;

    assign init_done   = init_done_reg;
    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_matched = out_matched_reg;
    assign out_index   = out_index_reg;
    assign out_flags   = out_flags_reg;

    assign rsel      = r_reg[RW-1:0];
    assign esel      = RW'(q_item.entry);
    assign entry_ok  = (32'(q_item.entry) < RULES);
    assign hp        = HPW'(rule_offset_reg[rsel]) + HPW'(j_reg);
    assign magic_end = {2'b00, q_item.start_offset} + {1'b0, q_item.length};
    assign cmp_mask  = rule_mask_reg[rsel] ? msk_q : 8'hFF;
    assign mismatch  = rule_magic_reg[rsel] ? (((hdr_q ^ pat_q) & cmp_mask) != 8'h00)
                                            : (ext_q != pat_q);
    // credentials imply open binary
    always_comb begin
        win_flags = rule_flags_reg[rsel];
        if (win_flags[FLAG_CREDS]) begin
            win_flags[FLAG_OPEN_BIN] = 1'b1;
        end
    end

    always_comb begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        init_done_next   = init_done_reg;
        ext_len_next     = ext_len_reg;
        dot_next         = dot_reg;
        ovf_next         = ovf_reg;
        r_next           = r_reg;
        j_next           = j_reg;
        path_next        = path_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_matched_next = out_matched_reg;
        out_index_next   = out_index_reg;
        out_flags_next   = out_flags_reg;
        q_pop            = 1'b0;
        hdr_we           = 1'b0;
        hdr_wa           = clr_idx_reg;
        hdr_wd           = 8'h00;
        ext_we           = 1'b0;
        pat_we           = 1'b0;
        rule_hdr_we      = 1'b0;
        rule_cmd_we      = 1'b0;

        out_free = !out_valid_reg || out_ready;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                hdr_we = 1'b1;
                if (clr_idx_reg == HA'(HEADER_BYTES - 1)) begin
                    clr_idx_next   = '0;
                    init_done_next = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop            = 1'b1;
                    out_valid_next   = 1'b1;
                    out_status_next  = STATUS_OK;
                    out_matched_next = 1'b0;
                    out_index_next   = 4'd0;
                    out_flags_next   = 4'd0;
                    case (q_item.mode)
                        MODE_BEGIN: begin
                            ext_len_next = '0;
                            dot_next     = 1'b0;
                            ovf_next     = 1'b0;
                            state_next   = ST_CLEAR;
                        end
                        MODE_HEADER: begin
                            if (32'(q_item.position) < HEADER_BYTES) begin
                                hdr_we = 1'b1;
                                hdr_wa = HA'(q_item.position);
                                hdr_wd = q_item.byte_value;
                            end
                        end
                        MODE_NAME: begin
                            if (q_item.byte_value == DOT_CHAR) begin
                                dot_next     = 1'b1;
                                ext_len_next = '0;
                                ovf_next     = 1'b0;
                            end else if (dot_reg) begin
                                if (32'(ext_len_reg) < EXT_BYTES) begin
                                    ext_we       = 1'b1;
                                    ext_len_next = ext_len_reg + 1'b1;
                                end else begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        MODE_RULE_HEADER: begin
                            if (!entry_ok || q_item.length == 9'd0 ||
                                32'(q_item.length) > PATTERN_SLOTS ||
                                (q_item.is_magic && 32'(magic_end) > HEADER_BYTES) ||
                                (!q_item.is_magic && 32'(q_item.length) > EXT_BYTES)) begin
                                out_status_next = STATUS_REJECT;
                            end else begin
                                rule_hdr_we = 1'b1;
                            end
                        end
                        MODE_RULE_BYTE: begin
                            if (entry_ok) begin
                                pat_we = 1'b1;
                            end else begin
                                out_status_next = STATUS_REJECT;
                            end
                        end
                        MODE_RULE_STATUS: begin
                            if (!entry_ok || !(q_item.command == CMD_DISABLE ||
                                q_item.command == CMD_ENABLE || q_item.command == CMD_DELETE)) begin
                                out_status_next = STATUS_REJECT;
                            end else begin
                                rule_cmd_we = 1'b1;
                            end
                        end
                        MODE_CLASSIFY: begin
                            path_next       = q_item.path_inaccessible;
                            out_status_next = STATUS_NO_MATCH;
                            if (global_enable) begin
                                out_valid_next = 1'b0;
                                r_next         = '0;
                                state_next     = ST_RULE;
                            end
                        end
                        default: begin
                            out_status_next = STATUS_REJECT;
                        end
                    endcase
                end
            end
            ST_RULE: begin
                if (r_reg == (RW+1)'(RULES)) begin
                    if (out_free) begin
                        out_valid_next   = 1'b1;
                        out_status_next  = STATUS_NO_MATCH;
                        out_matched_next = 1'b0;
                        out_index_next   = 4'd0;
                        out_flags_next   = 4'd0;
                        state_next       = ST_IDLE;
                    end
                end else if (!rule_valid_reg[rsel] || !rule_enable_reg[rsel]) begin
                    r_next = r_reg + 1'b1;
                end else if (!rule_magic_reg[rsel] &&
                             (!dot_reg || ovf_reg || 9'(ext_len_reg) != rule_size_reg[rsel])) begin
                    r_next = r_reg + 1'b1;
                end else begin
                    j_next     = 9'd0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (mismatch) begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_RULE;
                end else if (j_reg + 9'd1 == rule_size_reg[rsel]) begin
                    if (out_free) begin
                        out_valid_next   = 1'b1;
                        out_status_next  = path_reg ? STATUS_PATH_ERROR : STATUS_OK;
                        out_matched_next = 1'b1;
                        out_index_next   = 4'(r_reg);
                        out_flags_next   = win_flags;
                        state_next       = ST_IDLE;
                    end
                end else begin
                    j_next     = j_reg + 9'd1;
                    state_next = ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            init_done_reg <= 1'b0;
            ext_len_reg   <= '0;
            dot_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            r_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            init_done_reg <= init_done_next;
            ext_len_reg   <= ext_len_next;
            dot_reg       <= dot_next;
            ovf_reg       <= ovf_next;
            r_reg         <= r_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        path_reg        <= path_next;
        out_status_reg  <= out_status_next;
        out_matched_reg <= out_matched_next;
        out_index_reg   <= out_index_next;
        out_flags_reg   <= out_flags_next;
    end

    // rule table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RULES; i++) begin
                rule_valid_reg[i]  <= 1'b0;
                rule_enable_reg[i] <= 1'b0;
                rule_magic_reg[i]  <= 1'b0;
                rule_mask_reg[i]   <= 1'b0;
                rule_offset_reg[i] <= 8'd0;
                rule_size_reg[i]   <= 9'd0;
                rule_flags_reg[i]  <= 4'd0;
            end
        end else if (rule_hdr_we) begin
            rule_valid_reg[esel]  <= 1'b1;
            rule_enable_reg[esel] <= 1'b1;
            rule_magic_reg[esel]  <= q_item.is_magic;
            rule_mask_reg[esel]   <= q_item.has_mask;
            rule_offset_reg[esel] <= q_item.is_magic ? q_item.start_offset : 8'd0;
            rule_size_reg[esel]   <= q_item.length;
            rule_flags_reg[esel]  <= q_item.action_flags;
        end else if (rule_cmd_we) begin
            case (q_item.command)
                CMD_DISABLE: rule_enable_reg[esel] <= 1'b0;
                CMD_ENABLE:  rule_enable_reg[esel] <= 1'b1;
                default: begin
                    rule_valid_reg[esel]  <= 1'b0;
                    rule_enable_reg[esel] <= 1'b0;
                end
            endcase
        end
    end

    // memories: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_mem[hdr_wa] <= hdr_wd;
        end
        hdr_q <= hdr_mem[hp[HA-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (ext_we) begin
            ext_mem[ext_len_reg[EAW-1:0]] <= q_item.byte_value;
        end
        ext_q <= ext_mem[j_reg[EAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (pat_we) begin
            pat_mem[{esel, q_item.position}] <= q_item.byte_value;
            msk_mem[{esel, q_item.position}] <= q_item.mask_value;
        end
        pat_q <= pat_mem[{rsel, j_reg[7:0]}];
        msk_q <= msk_mem[{rsel, j_reg[7:0]}];
    end

    `MSC_ASSERT_NEXT(a_read_to_cmp, state_reg == ST_READ, state_reg == ST_CMP, "read not followed by compare")
    `MSC_ASSERT_ALWAYS(a_walk_bound, 32'(r_reg) <= RULES, "rule walk ran past the table")
    `MSC_ASSERT_ALWAYS(a_init_clear, init_done_reg || state_reg == ST_CLEAR, "left clear before init")

endmodule

// File: design/masked_signature_classifier.sv
// Masked signature classifier: header and file-name extension matched against a rule table.
//
// Items arrive on the s_ stream (mode in s_tuser), are queued, and are executed
// one at a time by the back end; each item yields exactly one result on the m_
// stream (status in m_tuser). An accepted item reaches the back end at the next
// edge at the earliest, and its result is presented in the cycle after that.
// Header bytes, name characters, rule writes and rule status commands are done
// as they are taken from the queue. A begin-file item clears the header store
// with one write per cycle; the next item starts once the sweep is done. With
// global_enable clear a classify yields no match from the idle state; with it
// set the rules are walked in index order, skipping invalid and disabled rules
// and extension rules that cannot match (no dot, overflowed or other length).
// A compared rule is opened in ST_RULE, and each pattern byte passes a read
// state (header, extension, pattern and mask memories) and a compare state.
// The first mismatch moves to the next rule, and the lowest matching rule wins,
// its result issuing from the compare of its last byte; with no match the
// result issues from ST_RULE once the walk passes the last rule. After reset
// the header store is swept to zero with s_tready held low. A four-deep item
// queue lets the front keep accepting while the back end walks. The back end
// starts a new item only when the result register is empty or its result is
// taken in that cycle, so a result waiting for m_tready stalls the back end
// while the queue keeps filling. The user must write global_enable through
// cfg_wr_en/cfg_wr_data only while the block is idle, which it does not enforce.
module masked_signature_classifier
    import msc_pkg::*;
#(
    parameter int RULES        = 16,
    parameter int HEADER_BYTES = 256,
    parameter int EXT_BYTES    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry[3:0] position[11:4] byte_value[19:12] mask_value[27:20] is_magic[28]
    // has_mask[29] start_offset[37:30] length[46:38] action_flags[50:47]
    // command[52:51] path_inaccessible[53], zero fill above
    input  logic [55:0] s_tdata,
    // mode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // matched[0] match_index[4:1] match_flags[8:5], zero fill above
    output logic [15:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);

    logic       global_enable_reg;
    item_t      in_item, head_item;
    logic       q_full, q_not_empty, q_pop, init_done, push;
    logic       matched;
    logic [3:0] match_index, match_flags;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            global_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            global_enable_reg <= cfg_wr_data;
        end
    end

    // unpack the incoming item
    always_comb begin
        in_item.mode              = s_tuser;
        in_item.entry             = s_tdata[3:0];
        in_item.position          = s_tdata[11:4];
        in_item.byte_value        = s_tdata[19:12];
        in_item.mask_value        = s_tdata[27:20];
        in_item.is_magic          = s_tdata[28];
        in_item.has_mask          = s_tdata[29];
        in_item.start_offset      = s_tdata[37:30];
        in_item.length            = s_tdata[46:38];
        in_item.action_flags      = s_tdata[50:47];
        in_item.command           = s_tdata[52:51];
        in_item.path_inaccessible = s_tdata[53];
    end

    assign s_tready = !q_full && init_done;
    assign push     = s_tvalid && s_tready;
    assign m_tdata  = {7'd0, match_flags, match_index, matched};

    msc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    msc_engine #(
        .RULES        (RULES),
        .HEADER_BYTES (HEADER_BYTES),
        .EXT_BYTES    (EXT_BYTES)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .global_enable (global_enable_reg),
        .q_valid       (q_not_empty),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .init_done     (init_done),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (m_tuser),
        .out_matched   (matched),
        .out_index     (match_index),
        .out_flags     (match_flags)
    );

endmodule

// File: tb/msc_checker.sv
// Checker for the masked signature classifier: predicts every result and compares it.
module msc_checker
    import msc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [1:0] status;
        logic       matched;
        logic [3:0] index;
        logic [3:0] flags;
    } verdict_t;

    verdict_t   verdict_q[$];

    logic       cls_enable;
    logic [7:0] hdr_mem [256];
    logic [7:0] ext_mem [64];
    int         ext_len;
    logic       dot_seen, ext_ovf;
    logic       r_valid [16], r_en [16], r_magic [16], r_mask [16];
    logic [7:0] r_off [16];
    logic [8:0] r_len [16];
    logic [3:0] r_flags [16];
    logic [7:0] pat_mem [16][256];
    logic [7:0] msk_mem [16][256];

    function automatic logic rule_hit(int r);
        logic [7:0] m;
        int n;
        n = r_len[r];
        if (!r_magic[r]) begin
            if (!dot_seen || ext_ovf || ext_len != n || n > 64) return 1'b0;
            for (int j = 0; j < n; j++)
                if (ext_mem[j] != pat_mem[r][j]) return 1'b0;
            return 1'b1;
        end
        for (int j = 0; j < n && j < 256; j++) begin
            m = r_mask[r] ? msk_mem[r][j] : 8'hFF;
            if ((((r_off[r] + j) < 256 ? hdr_mem[r_off[r] + j] : 8'h00)
                 ^ pat_mem[r][j]) & m) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one item to the shadow state and returns its result.
    function automatic verdict_t classify_item(logic [2:0] md, logic [55:0] d);
        verdict_t   v;
        logic [3:0] e;
        logic [7:0] pos, bv, off;
        logic [8:0] len;
        logic       im;
        logic       found;
        e = d[3:0]; pos = d[11:4]; bv = d[19:12]; im = d[28];
        off = d[37:30]; len = d[46:38];
        v = '0;
        v.status = STATUS_OK;
        found = 1'b0;
        case (md)
            MODE_BEGIN: begin
                foreach (hdr_mem[i]) hdr_mem[i] = 8'h00;
                ext_len = 0; dot_seen = 1'b0; ext_ovf = 1'b0;
            end
            MODE_HEADER: hdr_mem[pos] = bv;
            MODE_NAME: begin
                if (bv == DOT_CHAR) begin
                    dot_seen = 1'b1; ext_len = 0; ext_ovf = 1'b0;
                end else if (dot_seen) begin
                    if (ext_len < 64) begin
                        ext_mem[ext_len] = bv;
                        ext_len++;
                    end else ext_ovf = 1'b1;
                end
            end
            MODE_RULE_HEADER: begin
                if (len == 0 || len > 256 || (im && off + len > 256) || (!im && len > 64)) begin
                    v.status = STATUS_REJECT;
                end else begin
                    r_valid[e] = 1'b1; r_en[e] = 1'b1; r_magic[e] = im;
                    r_mask[e] = d[29]; r_off[e] = im ? off : 8'd0;
                    r_len[e] = len; r_flags[e] = d[50:47];
                end
            end
            MODE_RULE_BYTE: begin
                pat_mem[e][pos] = bv;
                msk_mem[e][pos] = d[27:20];
            end
            MODE_RULE_STATUS: begin
                case (d[52:51])
                    CMD_DISABLE: r_en[e] = 1'b0;
                    CMD_ENABLE:  r_en[e] = 1'b1;
                    CMD_DELETE:  begin r_valid[e] = 1'b0; r_en[e] = 1'b0; end
                    default:     v.status = STATUS_REJECT;
                endcase
            end
            MODE_CLASSIFY: begin
                v.status = STATUS_NO_MATCH;
                if (cls_enable) begin
                    for (int r = 0; r < 16; r++) begin
                        if (!found && r_valid[r] && r_en[r] && rule_hit(r)) begin
                            found = 1'b1;
                            v.matched = 1'b1;
                            v.index = r[3:0];
                            v.flags = r_flags[r];
                            if (v.flags[FLAG_CREDS]) v.flags[FLAG_OPEN_BIN] = 1'b1;
                            v.status = d[53] ? STATUS_PATH_ERROR : STATUS_OK;
                        end
                    end
                end
            end
            default: v.status = STATUS_REJECT;
        endcase
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t want, got;
        if (!aresetn) begin
            cls_enable = 1'b1;
            foreach (hdr_mem[i]) hdr_mem[i] = 8'h00;
            ext_len = 0; dot_seen = 1'b0; ext_ovf = 1'b0;
            for (int r = 0; r < 16; r++) begin
                r_valid[r] = 1'b0; r_en[r] = 1'b0; r_magic[r] = 1'b0; r_mask[r] = 1'b0;
                r_off[r] = '0; r_len[r] = '0; r_flags[r] = '0;
            end
            verdict_q.delete();
            errors <= 0;
            pending <= 0;
        end else begin
            if (cfg_wr_en) cls_enable = cfg_wr_data;
            if (s_tvalid && s_tready) verdict_q.push_back(classify_item(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[0], m_tdata[4:1], m_tdata[8:5]};
                if (verdict_q.size() == 0) begin
                    if (errors < 10) $display("unexpected result %h", got);
                    errors <= errors + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (want != got) begin
                        if (errors < 10)
                            $display("mismatch: expected st=%0d m=%0d i=%0d f=%h, got st=%0d m=%0d i=%0d f=%h",
                                     want.status, want.matched, want.index, want.flags,
                                     got.status, got.matched, got.index, got.flags);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= verdict_q.size();
        end
    end
endmodule

// File: tb/tb_top.sv
// Stimulus and verdict for the masked signature classifier.
module tb_top;
    import msc_pkg::*;

    localparam int WATCHDOG = 60000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b1;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    int          errors, pending;

    // idling on or off for the current phase, both sides
    logic        gaps_on = 1'b1;
    int          sent = 0;
    int          stall_left = 0;
    int          quiet = 0;

    // stimulus view of the rule table, to keep compares on written bytes
    logic [7:0]  sh_pat [16][256];
    logic [7:0]  sh_msk [16][256];
    logic        sh_wr [16][256];
    logic        sh_magic [16], sh_hm [16];
    logic [7:0]  sh_off [16];
    logic [8:0]  sh_len [16];
    logic        sh_has [16];

    always #5 aclk = ~aclk;

    masked_signature_classifier DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    msc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    // receiver: while gaps are on, stalls at random after a taken result
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                if (gaps_on && $urandom_range(0, 1)) begin
                    m_tready <= 1'b0;
                    stall_left <= $urandom_range(1, 16);
                end
            end
        end else if (stall_left <= 1) begin
            m_tready <= 1'b1;
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [55:0] pack(logic [3:0] e, logic [7:0] pos, logic [7:0] bv,
                                         logic [7:0] mv, logic im, logic hm, logic [7:0] off,
                                         logic [8:0] len, logic [3:0] fl, logic [1:0] cmd,
                                         logic pi);
        return {2'b00, pi, cmd, fl, len, off, hm, im, mv, bv, pos, e};
    endfunction

    function automatic logic hdr_accepts(logic im, logic [7:0] off, logic [8:0] len);
        return !(len == 0 || len > 256 || (im && off + len > 256) || (!im && len > 64));
    endfunction

    function automatic logic covered(logic [3:0] e, logic [8:0] len);
        for (int j = 0; j < len; j++) if (!sh_wr[e][j]) return 1'b0;
        return 1'b1;
    endfunction

    // One item; valid stays high after acceptance until the next item or drop_valid.
    task automatic put(logic [2:0] md, logic [55:0] d);
        int g;
        g = gaps_on ? $urandom_range(0, 16) : 0;
        repeat (g) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= md;
        do @(posedge aclk); while (!s_tready);
        sent++;
        // keep the shadow table in step with what was sent
        case (md)
            MODE_RULE_BYTE: begin
                sh_pat[d[3:0]][d[11:4]] = d[19:12];
                sh_msk[d[3:0]][d[11:4]] = d[27:20];
                sh_wr[d[3:0]][d[11:4]] = 1'b1;
            end
            MODE_RULE_HEADER:
                if (hdr_accepts(d[28], d[37:30], d[46:38])) begin
                    sh_has[d[3:0]] = 1'b1; sh_magic[d[3:0]] = d[28]; sh_hm[d[3:0]] = d[29];
                    sh_off[d[3:0]] = d[28] ? d[37:30] : 8'd0; sh_len[d[3:0]] = d[46:38];
                end
            default: ;
        endcase
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic simple(logic [2:0] md, logic [7:0] bv, logic pi);
        put(md, pack(4'd0, 8'd0, bv, 8'd0, 1'b0, 1'b0, 8'd0, 9'd0, 4'd0, 2'd0, pi));
    endtask

    task automatic rule_cmd(logic [3:0] e, logic [1:0] cmd);
        put(MODE_RULE_STATUS, pack(e, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 9'd0, 4'd0, cmd, 1'b0));
    endtask

    // every pattern byte the rule can read is written before its header goes in
    task automatic prog_rule(logic [3:0] e, logic im, logic hm, logic [7:0] off,
                             logic [8:0] len, logic [3:0] fl);
        logic [7:0] b;
        for (int j = 0; j < len; j++) begin
            if (!sh_wr[e][j] || $urandom_range(0, 1)) begin
                b = 8'($urandom_range(0, 255));
                if (!im && b == DOT_CHAR) b = 8'h41;
                put(MODE_RULE_BYTE, pack(e, j[7:0], b, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                                         8'd0, 9'd0, 4'd0, 2'd0, 1'b0));
            end
        end
        put(MODE_RULE_HEADER, pack(e, 8'd0, 8'd0, 8'd0, im, hm, off, len, fl, 2'd0, 1'b0));
    endtask

    task automatic rand_rule();
        logic       im;
        logic [8:0] len;
        logic [7:0] off;
        im = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 39) == 0) len = im ? 9'd256 : 9'd64;
        else len = 9'($urandom_range(1, 8));
        off = im ? 8'($urandom_range(0, 256 - len)) : 8'($urandom_range(0, 255));
        prog_rule(4'($urandom_range(0, 15)), im, 1'($urandom_range(0, 1)), off, len,
                  4'($urandom_range(0, 15)));
    endtask

    // begin, header, name, classify; built to hit rule e most of the time
    task automatic file_for(logic [3:0] e);
        logic [7:0] m, b;
        int         n;
        simple(MODE_BEGIN, 8'd0, 1'b0);
        n = $urandom_range(0, 6);
        repeat (n)
            put(MODE_HEADER, pack(4'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  8'd0, 1'b0, 1'b0, 8'd0, 9'd0, 4'd0, 2'd0, 1'b0));
        if (sh_has[e] && sh_magic[e]) begin
            for (int j = 0; j < sh_len[e]; j++) begin
                m = sh_hm[e] ? sh_msk[e][j] : 8'hFF;
                b = (sh_pat[e][j] & m) | (8'($urandom_range(0, 255)) & ~m);
                if ($urandom_range(0, 15) == 0) b = 8'($urandom_range(0, 255));
                put(MODE_HEADER, pack(4'd0, 8'(sh_off[e] + j), b, 8'd0, 1'b0, 1'b0, 8'd0, 9'd0,
                                      4'd0, 2'd0, 1'b0));
            end
        end
        n = $urandom_range(0, 4);
        repeat (n) simple(MODE_NAME, ($urandom_range(0, 3) == 0) ? DOT_CHAR
                                                                 : 8'($urandom_range(0, 255)),
                          1'b0);
        if ($urandom_range(0, 7) != 0) simple(MODE_NAME, DOT_CHAR, 1'b0);
        if (sh_has[e] && !sh_magic[e] && $urandom_range(0, 7) != 0) begin
            for (int j = 0; j < sh_len[e]; j++) simple(MODE_NAME, sh_pat[e][j], 1'b0);
            // occasional overflow of the extension buffer
            if ($urandom_range(0, 19) == 0) repeat (65) simple(MODE_NAME, 8'h61, 1'b0);
            else if ($urandom_range(0, 5) == 0) simple(MODE_NAME, 8'h7A, 1'b0);
        end else begin
            n = $urandom_range(0, 5);
            repeat (n) simple(MODE_NAME, 8'($urandom_range('h30, 'h39)), 1'b0);
        end
        simple(MODE_CLASSIFY, 8'd0, 1'($urandom_range(0, 1)));
    endtask

    // random item of any mode; a header that would expose unwritten bytes is made empty
    task automatic noise();
        logic [55:0] d;
        logic [2:0]  md;
        d = 56'({$urandom(), $urandom()});
        d[55:54] = 2'b00;
        md = 3'($urandom_range(0, 7));
        if (md == MODE_RULE_HEADER && hdr_accepts(d[28], d[37:30], d[46:38])
            && !covered(d[3:0], d[46:38]))
            d[46:38] = 9'd0;
        put(md, d);
    endtask

    task automatic set_enable(logic v);
        drop_valid();
        while (pending != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int pick;
        for (int r = 0; r < 16; r++) begin
            sh_has[r] = 1'b0;
            for (int j = 0; j < 256; j++) sh_wr[r][j] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        set_enable(1'b1);

        // directed: extremes, every mode and command, each odd case
        put(3'd7, '0);                                   // undefined mode
        rule_cmd(4'd3, 2'd3);                            // undefined command
        rule_cmd(4'd5, CMD_ENABLE);                      // enable of an invalid rule
        put(MODE_RULE_HEADER, pack(4'd1, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 8'd0, 9'd0, 4'd0,
                                   2'd0, 1'b0));         // empty rule
        put(MODE_RULE_HEADER, pack(4'd1, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 8'd0, 9'd511, 4'hF,
                                   2'd0, 1'b0));         // too long
        put(MODE_RULE_HEADER, pack(4'd1, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 8'd255, 9'd2, 4'd0,
                                   2'd0, 1'b0));         // runs past the header
        put(MODE_RULE_HEADER, pack(4'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 9'd65, 4'd0,
                                   2'd0, 1'b0));         // extension too long
        put(MODE_RULE_BYTE, pack(4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0, 9'd0, 4'd0,
                                 2'd0, 1'b0));
        prog_rule(4'd0, 1'b1, 1'b1, 8'd252, 9'd4, 4'd4); // credentials force open binary
        file_for(4'd0);
        simple(MODE_CLASSIFY, 8'd0, 1'b1);               // match with inaccessible path
        prog_rule(4'd2, 1'b0, 1'b0, 8'd0, 9'd3, 4'hF);
        file_for(4'd2);
        rule_cmd(4'd0, CMD_DISABLE);
        simple(MODE_CLASSIFY, 8'd0, 1'b0);
        rule_cmd(4'd2, CMD_DELETE);
        simple(MODE_CLASSIFY, 8'd0, 1'b0);
        simple(MODE_BEGIN, 8'd0, 1'b0);
        simple(MODE_NAME, 8'h00, 1'b0);                  // no dot seen
        simple(MODE_CLASSIFY, 8'd0, 1'b0);

        // random phases; each phase sets the enable, odd phases run without gaps
        for (int ph = 0; ph < 6; ph++) begin
            set_enable((ph % 3) != 1);
            gaps_on = (ph % 2) == 0;
            while (sent < 210 * (ph + 1) + 20) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) noise();
                else if (pick < 35) rand_rule();
                else if (pick < 43) rule_cmd(4'($urandom_range(0, 15)),
                                             2'($urandom_range(0, 3)));
                else file_for(4'($urandom_range(0, 15)));
            end
        end

        drop_valid();
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
